@@ design/ewma_shift_detector_assert.svh @@
// assertion macros for the ewma shift detector checker
`ifndef EWMA_SHIFT_DETECTOR_ASSERT_SVH
`define EWMA_SHIFT_DETECTOR_ASSERT_SVH

// same-cycle implication
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/esd_pkg.sv @@
// shared constants, types and codes of the ewma shift detector
package esd_pkg;

    localparam int TRAIN_LEN_DEF   = 5;
    localparam int SAMPLE_BITS_DEF = 8;

    localparam int SAMPLE_W = 8;
    localparam int TS_W     = 16;
    localparam int GAIN_W   = 16;
    localparam int LW_W     = 4;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 32;
    localparam int SUM_W    = 40;
    localparam int FRAC_W   = 16;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 16;

    localparam int MUL_AW = 32;
    localparam int MUL_BW = 24;
    localparam int MUL_PW = 50;
    localparam int MUL_NW = 5;
    localparam int DIV_W  = 41;

    localparam logic [MUL_NW-1:0] NB_SQ     = MUL_NW'(MEAN_W);
    localparam logic [MUL_NW-1:0] NB_GAIN   = MUL_NW'(GAIN_W);
    localparam logic [MUL_NW-1:0] NB_GAIN_C = MUL_NW'(GAIN_W + 1);
    localparam logic [MUL_NW-1:0] NB_LW     = MUL_NW'(LW_W);

    localparam logic [MUL_PW-1:0] MUL_ROUND = MUL_PW'(1) << (FRAC_W - 1);
    localparam logic [GAIN_W:0]   GAIN_ONE  = (GAIN_W + 1)'(1) << GAIN_W;

    localparam logic [GAIN_W-1:0] MEAN_GAIN_RST = 16'd5243;
    localparam logic [GAIN_W-1:0] VAR_GAIN_RST  = 16'd655;
    localparam logic [LW_W-1:0]   LIMIT_RST     = 4'd3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MEAN_GAIN     = 2'd0,
        CFG_VARIANCE_GAIN = 2'd1,
        CFG_LIMIT_WIDTH   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MDIV,
        S_R_DIFF,
        S_R_SQ,
        S_R_MG,
        S_VDIV,
        S_D_DIFF,
        S_D_SQ,
        S_D_MG,
        S_D_LIM,
        S_D_VG1,
        S_D_VG2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic              acc;
        logic [MUL_NW-1:0] nbits;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
    } t_div_req;

endpackage

@@ design/esd_mul.sv @@
// bit-serial shift-add multiplier with rounding preload and accumulate
module esd_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  esd_pkg::t_mul_req              i_req,
    output logic                           o_done,
    output logic [esd_pkg::MUL_PW-1:0]     o_p
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [esd_pkg::MUL_NW-1:0]    r_cnt, n_cnt;
    logic [esd_pkg::MUL_PW-1:0]    r_a, n_a;
    logic [esd_pkg::MUL_BW-1:0]    r_b, n_b;
    logic [esd_pkg::MUL_PW-1:0]    r_p, n_p;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        if (i_req.start) begin
            n_a    = esd_pkg::MUL_PW'(i_req.a);
            n_b    = i_req.b;
            n_cnt  = i_req.nbits;
            n_p    = i_req.acc ? r_p : esd_pkg::MUL_ROUND;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_p = r_p + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - esd_pkg::MUL_NW'(1);
            if (r_cnt == esd_pkg::MUL_NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_p <= n_p;
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

@@ design/esd_div.sv @@
// restoring divider by the training length, one quotient bit per cycle
module esd_div #(
    parameter int TRAIN_LEN = esd_pkg::TRAIN_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esd_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [esd_pkg::DIV_W-1:0]     o_quot
);

    localparam int RW    = $clog2(TRAIN_LEN);
    localparam int CNT_W = $clog2(esd_pkg::DIV_W + 1);
    localparam logic [RW:0]      DIVISOR = (RW + 1)'(TRAIN_LEN);
    localparam logic [CNT_W-1:0] STEPS   = CNT_W'(esd_pkg::DIV_W);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [esd_pkg::DIV_W-1:0]  r_num, n_num;
    logic [RW-1:0]              r_rem, n_rem;
    logic [RW:0]                trial;
    logic                       ge;

    always_comb begin
        trial  = {r_rem, r_num[esd_pkg::DIV_W-1]};
        ge     = (trial >= DIVISOR);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_num  = i_req.num;
            n_rem  = '0;
            n_cnt  = STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? RW'(trial - DIVISOR) : trial[RW-1:0];
            n_num = {r_num[esd_pkg::DIV_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ design/ewma_shift_detector.sv @@
// top level: sequencer, training store, ewma state, config and result register
//
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_stall    i_sample, i_timestamp
// out      out  o_out_valid / i_out_stall  o_ready_res, o_shift_found, o_timestamp_out,
//                                          o_mean_estimate, o_variance_estimate
// cfg      in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// one request at a time; all multiplies go bit-serially through one shift-add unit
// training request: stores the sample; the last one also runs the 41-step serial divide
// replay request: square and gain multiply per sample, then the serial divide
// detect request: multiplies of 24, 16, 4, 16 and 17 bits
// synchronous active-low reset clears state and loads the register defaults
// a finished result waits in the output register while the next request is taken
module ewma_shift_detector #(
    parameter int TRAIN_LEN   = esd_pkg::TRAIN_LEN_DEF,
    parameter int SAMPLE_BITS = esd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [esd_pkg::SAMPLE_W-1:0]      i_sample,
    input  logic [esd_pkg::TS_W-1:0]          i_timestamp,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_ready_res,
    output logic                              o_shift_found,
    output logic [esd_pkg::TS_W-1:0]          o_timestamp_out,
    output logic [esd_pkg::MEAN_W-1:0]        o_mean_estimate,
    output logic [esd_pkg::VAR_W-1:0]         o_variance_estimate,
    input  logic                              i_cfg_we,
    input  logic [esd_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [esd_pkg::CFG_DW-1:0]        i_cfg_data
);

    localparam int XW  = (SAMPLE_BITS < esd_pkg::SAMPLE_W) ? SAMPLE_BITS : esd_pkg::SAMPLE_W;
    localparam int CW  = $clog2(TRAIN_LEN + 1);
    localparam int IW  = $clog2(TRAIN_LEN);
    localparam int TSW = XW + CW;
    localparam logic [CW-1:0] T_C    = CW'(TRAIN_LEN);
    localparam logic [CW-1:0] T_LAST = CW'(TRAIN_LEN - 1);
    localparam logic [esd_pkg::DIV_W-1:0] HALF_T = esd_pkg::DIV_W'(TRAIN_LEN / 2);

    esd_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_detect, n_detect;
    logic [CW-1:0]                  r_idx, n_idx;
    logic [XW-1:0]                  r_x, n_x;
    logic [esd_pkg::TS_W-1:0]       r_ts, n_ts;
    logic [XW-1:0]                  r_store [TRAIN_LEN];
    logic [TSW-1:0]                 r_tsum, n_tsum;
    logic [esd_pkg::MEAN_W-1:0]     r_mean, n_mean;
    logic [esd_pkg::VAR_W-1:0]      r_var, n_var;
    logic [esd_pkg::SUM_W-1:0]      r_acc, n_acc;
    logic [esd_pkg::MEAN_W-1:0]     r_e, n_e;
    logic                           r_up, n_up;
    logic [esd_pkg::VAR_W-1:0]      r_s, n_s;
    logic                           r_ready, n_ready;
    logic                           r_flag, n_flag;
    logic [esd_pkg::GAIN_W-1:0]     r_mean_gain;
    logic [esd_pkg::GAIN_W-1:0]     r_var_gain;
    logic [esd_pkg::LW_W-1:0]       r_limit;
    logic                           r_out_valid, n_out_valid;
    logic                           r_o_ready, n_o_ready;
    logic                           r_o_flag, n_o_flag;
    logic [esd_pkg::TS_W-1:0]       r_o_ts, n_o_ts;
    logic [esd_pkg::MEAN_W-1:0]     r_o_mean, n_o_mean;
    logic [esd_pkg::VAR_W-1:0]      r_o_var, n_o_var;

    logic                           store_we;
    esd_pkg::t_mul_req              mul_req;
    esd_pkg::t_div_req              div_req;
    logic                           mul_done;
    logic [esd_pkg::MUL_PW-1:0]     mul_p;
    logic                           div_done;
    logic [esd_pkg::DIV_W-1:0]      div_q;

    logic [XW-1:0]                  xi;
    logic [esd_pkg::MEAN_W-1:0]     xi16;
    logic                           up;
    logic [esd_pkg::MEAN_W-1:0]     e;
    logic [esd_pkg::VAR_W-1:0]      p_sat;
    logic [esd_pkg::MEAN_W-1:0]     delta;
    logic [esd_pkg::MEAN_W-1:0]     mean_step;
    logic [esd_pkg::SUM_W:0]        acc_sum;
    logic [esd_pkg::SUM_W-1:0]      acc_sat;
    logic                           flag_hit;
    logic [esd_pkg::VAR_W-1:0]      q_sat;
    logic [TSW-1:0]                 tsum_next;
    logic [esd_pkg::GAIN_W:0]       vg_c;

    esd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    esd_div #(
        .TRAIN_LEN (TRAIN_LEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_in_stall = (r_state != esd_pkg::S_IDLE);

    always_comb begin
        // datapath terms shared by the states
        if (r_state == esd_pkg::S_R_DIFF && r_idx != T_C) begin
            xi = r_store[r_idx[IW-1:0]];
        end else begin
            xi = r_x;
        end
        xi16 = esd_pkg::MEAN_W'(xi) << esd_pkg::FRAC_W;
        up   = (xi16 >= r_mean);
        e    = up ? (xi16 - r_mean) : (r_mean - xi16);

        p_sat = (|mul_p[esd_pkg::MUL_PW-1:esd_pkg::FRAC_W+esd_pkg::VAR_W]) ?
                '1 : mul_p[esd_pkg::FRAC_W+esd_pkg::VAR_W-1:esd_pkg::FRAC_W];
        delta     = mul_p[esd_pkg::FRAC_W+esd_pkg::MEAN_W-1:esd_pkg::FRAC_W];
        mean_step = r_up ? (r_mean + delta) : (r_mean - delta);
        acc_sum   = {1'b0, r_acc} +
                    (esd_pkg::SUM_W + 1)'(mul_p[esd_pkg::MUL_PW-1:esd_pkg::FRAC_W]);
        acc_sat   = acc_sum[esd_pkg::SUM_W] ? '1 : acc_sum[esd_pkg::SUM_W-1:0];
        flag_hit  = ((esd_pkg::MUL_PW'(r_e) + esd_pkg::MUL_ROUND) >= mul_p);
        q_sat     = (|div_q[esd_pkg::DIV_W-1:esd_pkg::VAR_W]) ? '1 : div_q[esd_pkg::VAR_W-1:0];
        tsum_next = r_tsum + TSW'(r_x);
        vg_c      = esd_pkg::GAIN_ONE - {1'b0, r_var_gain};

        n_state     = r_state;
        n_count     = r_count;
        n_detect    = r_detect;
        n_idx       = r_idx;
        n_x         = r_x;
        n_ts        = r_ts;
        n_tsum      = r_tsum;
        n_mean      = r_mean;
        n_var       = r_var;
        n_acc       = r_acc;
        n_e         = r_e;
        n_up        = r_up;
        n_s         = r_s;
        n_ready     = r_ready;
        n_flag      = r_flag;
        n_out_valid = r_out_valid;
        n_o_ready   = r_o_ready;
        n_o_flag    = r_o_flag;
        n_o_ts      = r_o_ts;
        n_o_mean    = r_o_mean;
        n_o_var     = r_o_var;
        store_we    = 1'b0;
        mul_req     = '0;
        div_req     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            esd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_sample[XW-1:0];
                    n_ts    = i_timestamp;
                    n_state = esd_pkg::S_START;
                end
            end
            esd_pkg::S_START: begin
                n_ready = r_detect;
                n_flag  = 1'b0;
                if (r_detect) begin
                    n_state = esd_pkg::S_D_DIFF;
                end else if (r_count != T_C) begin
                    store_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_tsum   = tsum_next;
                    if (r_count == T_LAST) begin
                        div_req.start = 1'b1;
                        div_req.num   = esd_pkg::DIV_W'({tsum_next, {esd_pkg::FRAC_W{1'b0}}})
                                        + HALF_T;
                        n_state       = esd_pkg::S_MDIV;
                    end else begin
                        n_state = esd_pkg::S_DONE;
                    end
                end else begin
                    n_idx   = CW'(1);
                    n_acc   = '0;
                    n_state = esd_pkg::S_R_DIFF;
                end
            end
            esd_pkg::S_MDIV: begin
                if (div_done) begin
                    n_mean  = div_q[esd_pkg::MEAN_W-1:0];
                    n_state = esd_pkg::S_DONE;
                end
            end
            esd_pkg::S_R_DIFF, esd_pkg::S_D_DIFF: begin
                n_e           = e;
                n_up          = up;
                mul_req.start = 1'b1;
                mul_req.nbits = esd_pkg::NB_SQ;
                mul_req.a     = esd_pkg::MUL_AW'(e);
                mul_req.b     = esd_pkg::MUL_BW'(e);
                n_state       = (r_state == esd_pkg::S_R_DIFF) ? esd_pkg::S_R_SQ
                                                               : esd_pkg::S_D_SQ;
            end
            esd_pkg::S_R_SQ: begin
                if (mul_done) begin
                    n_acc         = acc_sat;
                    mul_req.start = 1'b1;
                    mul_req.nbits = esd_pkg::NB_GAIN;
                    mul_req.a     = esd_pkg::MUL_AW'(r_e);
                    mul_req.b     = esd_pkg::MUL_BW'(r_mean_gain);
                    n_state       = esd_pkg::S_R_MG;
                end
            end
            esd_pkg::S_R_MG: begin
                if (mul_done) begin
                    n_mean = mean_step;
                    if (r_idx == T_C) begin
                        div_req.start = 1'b1;
                        div_req.num   = esd_pkg::DIV_W'(r_acc) + HALF_T;
                        n_state       = esd_pkg::S_VDIV;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = esd_pkg::S_R_DIFF;
                    end
                end
            end
            esd_pkg::S_VDIV: begin
                if (div_done) begin
                    n_var    = q_sat;
                    n_detect = 1'b1;
                    n_state  = esd_pkg::S_DONE;
                end
            end
            esd_pkg::S_D_SQ: begin
                if (mul_done) begin
                    n_s           = p_sat;
                    mul_req.start = 1'b1;
                    mul_req.nbits = esd_pkg::NB_GAIN;
                    mul_req.a     = esd_pkg::MUL_AW'(r_e);
                    mul_req.b     = esd_pkg::MUL_BW'(r_mean_gain);
                    n_state       = esd_pkg::S_D_MG;
                end
            end
            esd_pkg::S_D_MG: begin
                if (mul_done) begin
                    n_mean        = mean_step;
                    mul_req.start = 1'b1;
                    mul_req.nbits = esd_pkg::NB_LW;
                    mul_req.a     = r_var;
                    mul_req.b     = esd_pkg::MUL_BW'(r_limit);
                    n_state       = esd_pkg::S_D_LIM;
                end
            end
            esd_pkg::S_D_LIM: begin
                if (mul_done) begin
                    n_flag        = flag_hit;
                    mul_req.start = 1'b1;
                    mul_req.nbits = esd_pkg::NB_GAIN;
                    mul_req.a     = r_s;
                    mul_req.b     = esd_pkg::MUL_BW'(r_var_gain);
                    n_state       = esd_pkg::S_D_VG1;
                end
            end
            esd_pkg::S_D_VG1: begin
                if (mul_done) begin
                    mul_req.start = 1'b1;
                    mul_req.acc   = 1'b1;
                    mul_req.nbits = esd_pkg::NB_GAIN_C;
                    mul_req.a     = r_var;
                    mul_req.b     = esd_pkg::MUL_BW'(vg_c);
                    n_state       = esd_pkg::S_D_VG2;
                end
            end
            esd_pkg::S_D_VG2: begin
                if (mul_done) begin
                    n_var   = p_sat;
                    n_state = esd_pkg::S_DONE;
                end
            end
            esd_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_ready   = r_ready;
                    n_o_flag    = r_flag;
                    n_o_ts      = r_ts;
                    n_o_mean    = r_mean;
                    n_o_var     = r_var;
                    n_state     = esd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esd_pkg::S_IDLE;
            r_count     <= '0;
            r_detect    <= 1'b0;
            r_tsum      <= '0;
            r_mean      <= '0;
            r_var       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_detect    <= n_detect;
            r_tsum      <= n_tsum;
            r_mean      <= n_mean;
            r_var       <= n_var;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_x       <= n_x;
        r_ts      <= n_ts;
        r_acc     <= n_acc;
        r_e       <= n_e;
        r_up      <= n_up;
        r_s       <= n_s;
        r_ready   <= n_ready;
        r_flag    <= n_flag;
        r_o_ready <= n_o_ready;
        r_o_flag  <= n_o_flag;
        r_o_ts    <= n_o_ts;
        r_o_mean  <= n_o_mean;
        r_o_var   <= n_o_var;
    end

    // training store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[IW-1:0]] <= r_x;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_gain <= esd_pkg::MEAN_GAIN_RST;
            r_var_gain  <= esd_pkg::VAR_GAIN_RST;
            r_limit     <= esd_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                esd_pkg::CFG_MEAN_GAIN: begin
                    r_mean_gain <= i_cfg_data[esd_pkg::GAIN_W-1:0];
                end
                esd_pkg::CFG_VARIANCE_GAIN: begin
                    r_var_gain <= i_cfg_data[esd_pkg::GAIN_W-1:0];
                end
                esd_pkg::CFG_LIMIT_WIDTH: begin
                    r_limit <= i_cfg_data[esd_pkg::LW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_ready_res         = r_o_ready;
    assign o_shift_found       = r_o_flag;
    assign o_timestamp_out     = r_o_ts;
    assign o_mean_estimate     = r_o_mean;
    assign o_variance_estimate = r_o_var;

endmodule

@@ design/esd_checker.sv @@
// port-level checker for the ewma shift detector and its bind
`include "ewma_shift_detector_assert.svh"

module esd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_ready_res,
    input logic                              o_shift_found,
    input logic [esd_pkg::TS_W-1:0]          o_timestamp_out,
    input logic [esd_pkg::MEAN_W-1:0]        o_mean_estimate,
    input logic [esd_pkg::VAR_W-1:0]         o_variance_estimate
);

    logic [esd_pkg::TS_W+esd_pkg::MEAN_W+esd_pkg::VAR_W+1:0] out_data;

    assign out_data = {o_ready_res, o_shift_found, o_timestamp_out, o_mean_estimate,
                       o_variance_estimate};

    // one request in work at a time
    `ESD_ASSERT_NEXT(a_req_busy, i_in_valid && !o_in_stall, o_in_stall, "second request taken")

    // a flag only comes with detection active
    `ESD_ASSERT_NOW(a_flag_ready, o_out_valid && o_shift_found, o_ready_res, "flag without ready")

    `ESD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")

    `ESD_ASSERT_NEXT(a_data_hold, o_out_valid && i_out_stall, $stable(out_data), "result moved")

endmodule

bind ewma_shift_detector esd_checker u_esd_checker (.*);

@@ sim/ewma_shift_detector_tb.sv @@
// testbench for ewma_shift_detector: directed and randomised sensor readings checked against a built-in predictor
module ewma_shift_detector_tb;

    localparam int TRAIN_N     = esd_pkg::TRAIN_LEN_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int LONG_HOLD   = 400;
    localparam logic [63:0] VAR_CEIL = 64'hFFFF_FFFF;
    localparam logic [63:0] SUM_CEIL = (64'd1 << esd_pkg::SUM_W) - 64'd1;

    typedef struct packed {
        logic [esd_pkg::SAMPLE_W-1:0] value;
        logic [esd_pkg::TS_W-1:0]     stamp;
    } t_reading;

    typedef struct packed {
        logic                       ready;
        logic                       shift;
        logic [esd_pkg::TS_W-1:0]   stamp;
        logic [esd_pkg::MEAN_W-1:0] mean;
        logic [esd_pkg::VAR_W-1:0]  variance;
    } t_verdict;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       out_stall = 1'b0;
    t_reading                   offered = '0;
    logic                       cfg_we = 1'b0;
    esd_pkg::t_cfg_idx          cfg_index = esd_pkg::CFG_MEAN_GAIN;
    logic [esd_pkg::CFG_DW-1:0] cfg_data = '0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic                       o_ready_res;
    logic                       o_shift_found;
    logic [esd_pkg::TS_W-1:0]   o_timestamp_out;
    logic [esd_pkg::MEAN_W-1:0] o_mean_estimate;
    logic [esd_pkg::VAR_W-1:0]  o_variance_estimate;

    t_reading readings_waiting[$];
    t_verdict results_due[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       send_gap_pct = 24;
    int       hold_pct = 60;
    bit       long_hold_req = 1'b0;

    // predictor state and register copies
    logic [esd_pkg::SAMPLE_W-1:0] train_store [TRAIN_N];
    logic [3:0]                   train_count;
    logic [63:0]                  level;
    logic [esd_pkg::VAR_W-1:0]    spread;
    logic [esd_pkg::SUM_W-1:0]    err_sum;
    bit                           armed;
    logic [esd_pkg::GAIN_W-1:0]   gain_mean;
    logic [esd_pkg::GAIN_W-1:0]   gain_var;
    logic [esd_pkg::LW_W-1:0]     half_width;

    ewma_shift_detector dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample            (offered.value),
        .i_timestamp         (offered.stamp),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (out_stall),
        .o_ready_res         (o_ready_res),
        .o_shift_found       (o_shift_found),
        .o_timestamp_out     (o_timestamp_out),
        .o_mean_estimate     (o_mean_estimate),
        .o_variance_estimate (o_variance_estimate),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] gap_of(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [63:0] square_q16(input logic [63:0] e);
        return (e * e + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] follow_level(input logic [63:0] m, input logic [63:0] x16,
                                                 input logic [63:0] g);
        if (x16 >= m) begin
            return m + (((x16 - m) * g + 64'd32768) >> 16);
        end
        return m - (((m - x16) * g + 64'd32768) >> 16);
    endfunction

    function automatic void reset_detector();
        for (int i = 0; i < TRAIN_N; i++) train_store[i] = '0;
        train_count = '0;
        level       = '0;
        spread      = '0;
        err_sum     = '0;
        armed       = 1'b0;
        gain_mean   = esd_pkg::MEAN_GAIN_RST;
        gain_var    = esd_pkg::VAR_GAIN_RST;
        half_width  = esd_pkg::LIMIT_RST;
    endfunction

    function automatic t_verdict detection_step(input t_reading item);
        t_verdict    r;
        logic [63:0] x16;
        logic [63:0] prev_m;
        logic [63:0] prev_v;
        logic [63:0] e;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] z;
        logic [63:0] acc;
        logic [63:0] xi16;
        r   = '0;
        x16 = 64'(item.value) << 16;
        if (armed) begin
            prev_m = level;
            prev_v = 64'(spread);
            e      = gap_of(x16, prev_m);
            s      = square_q16(e);
            if (s > VAR_CEIL) s = VAR_CEIL;
            level  = follow_level(prev_m, x16, 64'(gain_mean));
            v      = (64'(gain_var) * s + (64'd65536 - 64'(gain_var)) * prev_v
                      + 64'd32768) >> 16;
            spread = (v > VAR_CEIL) ? '1 : v[esd_pkg::VAR_W-1:0];
            r.ready = 1'b1;
            r.shift = (e >= 64'(half_width) * prev_v);
        end else if (train_count < TRAIN_N) begin
            train_store[train_count] = item.value;
            train_count++;
            if (train_count == TRAIN_N) begin
                acc = '0;
                for (int i = 0; i < TRAIN_N; i++) acc += 64'(train_store[i]);
                level = ((acc << 16) + 64'(TRAIN_N / 2)) / 64'(TRAIN_N);
            end
        end else begin
            // training ends: replay the stored readings after the first, plus this one
            z   = level;
            acc = '0;
            for (int i = 1; i <= TRAIN_N; i++) begin
                if (i < TRAIN_N) xi16 = 64'(train_store[i]) << 16;
                else xi16 = x16;
                acc += square_q16(gap_of(xi16, z));
                if (acc > SUM_CEIL) acc = SUM_CEIL;
                z = follow_level(z, xi16, 64'(gain_mean));
            end
            err_sum = acc[esd_pkg::SUM_W-1:0];
            level   = z;
            v       = (acc + 64'(TRAIN_N / 2)) / 64'(TRAIN_N);
            spread  = (v > VAR_CEIL) ? '1 : v[esd_pkg::VAR_W-1:0];
            armed   = 1'b1;
        end
        r.stamp    = item.stamp;
        r.mean     = (level > 64'hFF_FFFF) ? '1 : level[esd_pkg::MEAN_W-1:0];
        r.variance = spread;
        return r;
    endfunction

    task automatic push_reading(input int v, input int ts);
        readings_waiting.push_back(t_reading'{value: esd_pkg::SAMPLE_W'(v),
                                              stamp: esd_pkg::TS_W'(ts)});
    endtask

    // runs of readings around a level with some noise, and the odd stray reading
    task automatic queue_readings(input int count);
        int n;
        int base;
        int noise;
        int run;
        int v;
        n = 0;
        while (n < count) begin
            base  = $urandom_range(255);
            noise = ($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(6);
            run   = $urandom_range(40, 4);
            for (int k = 0; k < run && n < count; k++) begin
                if ($urandom_range(19) == 0) begin
                    v = $urandom_range(255);
                end else begin
                    v = base + int'($urandom_range(2 * noise)) - noise;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                push_reading(v, $urandom_range(65535));
                n++;
            end
        end
    endtask

    task automatic program_registers(input logic [esd_pkg::GAIN_W-1:0] mg,
                                     input logic [esd_pkg::GAIN_W-1:0] vg,
                                     input logic [esd_pkg::LW_W-1:0] lw);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= esd_pkg::CFG_MEAN_GAIN;
        cfg_data  <= esd_pkg::CFG_DW'(mg);
        @(posedge clk);
        cfg_index <= esd_pkg::CFG_VARIANCE_GAIN;
        cfg_data  <= esd_pkg::CFG_DW'(vg);
        @(posedge clk);
        cfg_index <= esd_pkg::CFG_LIMIT_WIDTH;
        cfg_data  <= esd_pkg::CFG_DW'(lw);
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_mean  = mg;
        gain_var   = vg;
        half_width = lw;
    endtask

    // checked between edges so that the driver and monitor updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (readings_waiting.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge clk) begin
        logic take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && !o_in_stall;
            if (take) results_due.push_back(detection_step(offered));
            if (!in_valid || take) begin
                if (readings_waiting.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    offered  <= readings_waiting.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge clk) begin
        int hold_left;
        bit hold_done;
        if (long_hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < hold_pct);
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_verdict due;
        if (rst_n && o_out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result expected none actual timestamp %h", $time,
                         o_timestamp_out);
                mismatches++;
            end else begin
                due = results_due.pop_front();
                compare_field("ready_res", 64'(due.ready), 64'(o_ready_res));
                compare_field("shift_found", 64'(due.shift), 64'(o_shift_found));
                compare_field("timestamp_out", 64'(due.stamp), 64'(o_timestamp_out));
                compare_field("mean_estimate", 64'(due.mean), 64'(o_mean_estimate));
                compare_field("variance_estimate", 64'(due.variance),
                              64'(o_variance_estimate));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        reset_detector();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // training with full gains, then a flat run that drives the variance to zero
        program_registers('1, '1, '1);
        push_reading(0, 0);
        push_reading(255, 65535);
        push_reading(255, 16'h5555);
        push_reading(0, 16'hAAAA);
        push_reading(128, 1);
        push_reading(255, 2);
        for (int i = 0; i < 4; i++) push_reading(255, 3 + i);
        push_reading(0, 65534);
        wait_drained();

        // zero half-width
        program_registers(esd_pkg::MEAN_GAIN_RST, esd_pkg::VAR_GAIN_RST, '0);
        push_reading(10, 100);
        push_reading(200, 101);
        push_reading(200, 102);
        push_reading(255, 103);
        wait_drained();

        // frozen mean and variance
        program_registers('0, '0, 4'd1);
        push_reading(0, 200);
        push_reading(255, 201);
        push_reading(90, 202);
        push_reading(91, 203);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_gap_pct = 60;
                hold_pct     = 24;
            end
            if (phase == 4) begin
                send_gap_pct = 0;
                hold_pct     = 0;
            end
            case (phase)
                0: program_registers(esd_pkg::MEAN_GAIN_RST, esd_pkg::VAR_GAIN_RST,
                                     esd_pkg::LIMIT_RST);
                2: program_registers(esd_pkg::GAIN_W'($urandom_range(2000, 1)), '1, '1);
                4: program_registers('1, esd_pkg::GAIN_W'(1), esd_pkg::LW_W'(1));
                default: program_registers(esd_pkg::GAIN_W'($urandom_range(65535)),
                                           esd_pkg::GAIN_W'($urandom_range(65535)),
                                           esd_pkg::LW_W'($urandom_range(15)));
            endcase
            queue_readings(200);
            if (phase == 1) long_hold_req = 1'b1;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
